[rtl/bfsa_pkg.sv]
// ---------------------------------------------------------------------------
// bfsa_pkg: shared types and constants of the best-fit segment allocator
// Widths, operation and status codes, the controller states and the structs
// passed between the controller and the row of slot cells.
// ---------------------------------------------------------------------------
`default_nettype none
package bfsa_pkg;

    // geometry
    localparam int MAX_SEGMENTS = 16;
    localparam int ADDR_BITS    = 16;
    localparam int SLOT_W       = $clog2(MAX_SEGMENTS);

    // field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int SIZE_W   = 17;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int BASE_W   = 16;
    localparam int COUNT_W  = 9;
    localparam int MSZ_W    = 17;

    // internal address arithmetic
    localparam int LIM_W = ADDR_BITS + 1;
    localparam int END_W = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;
    localparam int CMP_W = (END_W > SIZE_W) ? END_W : SIZE_W;
    localparam int CNT_W = $clog2(2 * MAX_SEGMENTS + 1);
    localparam int POP_W = $clog2(MAX_SEGMENTS + 1);

    localparam logic [MSZ_W-1:0] MEM_SIZE_RST = MSZ_W'(65536);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_EXISTS   = 3'd1,
        STS_NOMEM    = 3'd2,
        STS_NOTFOUND = 3'd3,
        STS_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_PUSH
    } state_t;

    // broadcast control from the controller to every cell
    typedef struct packed {
        logic               tick;
        logic [TIME_W-1:0]  delta;
        logic               free;
        logic [ID_W-1:0]    id;
        logic [ADDR_BITS-1:0] wr_base;
        logic [SIZE_W-1:0]  wr_size;
        logic [TIME_W-1:0]  wr_time;
    } ctl_t;

    // gap token walking down the cell row
    typedef struct packed {
        logic             vld;
        logic [LIM_W-1:0] s;
        logic [LIM_W-1:0] e;
    } tok_t;

    // status of one cell back to the controller
    typedef struct packed {
        logic                 valid;
        logic                 id_match;
        logic                 expire;
        logic [ADDR_BITS-1:0] base;
        logic [END_W-1:0]     seg_end;
    } slot_t;

endpackage
`default_nettype wire

[rtl/bfsa_if.sv]
// ---------------------------------------------------------------------------
// bfsa interfaces: request, response and configuration channels
// Each channel carries valid, ready and its payload.
// ---------------------------------------------------------------------------
`default_nettype none
interface bfsa_req_if;
    logic                          valid;
    logic                          ready;
    logic [bfsa_pkg::OP_W-1:0]     operation;
    logic [bfsa_pkg::ID_W-1:0]     proc_id;
    logic [bfsa_pkg::SIZE_W-1:0]   req_size;
    logic [bfsa_pkg::TIME_W-1:0]   lifetime;
    logic [bfsa_pkg::TIME_W-1:0]   delta;
    modport source (output valid, operation, proc_id, req_size, lifetime, delta,
                    input ready);
    modport sink   (input valid, operation, proc_id, req_size, lifetime, delta,
                    output ready);
endinterface

interface bfsa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bfsa_pkg::STATUS_W-1:0] status;
    logic [bfsa_pkg::BASE_W-1:0]   base_addr;
    logic [bfsa_pkg::COUNT_W-1:0]  released_count;
    modport source (output valid, status, base_addr, released_count, input ready);
    modport sink   (input valid, status, base_addr, released_count, output ready);
endinterface

interface bfsa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bfsa_pkg::MSZ_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/bfsa_cell.sv]
// ---------------------------------------------------------------------------
// bfsa_cell: one segment slot of the allocator row
// Holds one segment, ages it, releases it by id, and narrows the end of the
// gap token passing through it.
// ---------------------------------------------------------------------------
`default_nettype none
module bfsa_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bfsa_pkg::ctl_t ctl,
    input  wire logic           wr_sel,
    input  wire bfsa_pkg::tok_t tok_in,
    output bfsa_pkg::tok_t      tok_out,
    output bfsa_pkg::slot_t     slot
);
    logic                               valid_reg, valid_next;
    logic [bfsa_pkg::ID_W-1:0]          id_reg;
    logic [bfsa_pkg::ADDR_BITS-1:0]     base_reg;
    logic [bfsa_pkg::SIZE_W-1:0]        size_reg;
    logic [bfsa_pkg::TIME_W-1:0]        time_reg, time_next;
    logic                               tok_vld_reg;
    logic [bfsa_pkg::LIM_W-1:0]         tok_s_reg, tok_e_reg;
    bfsa_pkg::tok_t                     tok_next;
    logic                               match, expire;
    logic [bfsa_pkg::LIM_W-1:0]         base_ext;

    assign match    = valid_reg && (id_reg == ctl.id);
    assign expire   = valid_reg && (time_reg <= ctl.delta);
    assign base_ext = bfsa_pkg::LIM_W'(base_reg);

    // slot update: write, release by id, ageing
    always_comb
    begin
        valid_next = valid_reg;
        time_next  = time_reg;
        if (wr_sel)
        begin
            valid_next = 1'b1;
            time_next  = ctl.wr_time;
        end
        else if (ctl.free && match)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.tick && valid_reg)
        begin
            if (expire)
                valid_next = 1'b0;
            else
                time_next = time_reg - ctl.delta;
        end
    end

    // gap token: pull the end down to a segment base inside the gap
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.vld && valid_reg && base_ext >= tok_in.s && base_ext < tok_in.e)
            tok_next.e = base_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            tok_vld_reg <= tok_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg  <= time_next;
        tok_s_reg <= tok_next.s;
        tok_e_reg <= tok_next.e;
        if (wr_sel)
        begin
            id_reg   <= ctl.id;
            base_reg <= ctl.wr_base;
            size_reg <= ctl.wr_size;
        end
    end

    assign tok_out       = {tok_vld_reg, tok_s_reg, tok_e_reg};
    assign slot.valid    = valid_reg;
    assign slot.id_match = match;
    assign slot.expire   = expire;
    assign slot.base     = base_reg;
    assign slot.seg_end  = bfsa_pkg::END_W'(base_reg) + bfsa_pkg::END_W'(size_reg);

endmodule
`default_nettype wire

[rtl/best_fit_segment_allocator_top.sv]
// ---------------------------------------------------------------------------
// best_fit_segment_allocator_top: best-fit segment allocator
// Requests arrive on req, one response per request leaves on rsp, and the
// memory size register is written through cfg.
//
// Usage:
//   req carries operation, proc_id, req_size, lifetime and delta; a request
//   is taken when valid and ready are high. Free, tick and unknown requests
//   go straight from idle to the push state. An allocate that passes the
//   id check walks gap tokens down the row of 16 slot cells: one token per
//   slot plus the zero start, each registered by every cell it passes, and
//   then goes through the finish and push states. An id clash or zero
//   size goes straight to push as well. One request is in flight at a time.
//   The response sits in an output register; a new request is taken while
//   it waits, and the next response holds until the receiver takes the old
//   one. cfg is always ready; the user must see that cfg is written only
//   while the block is idle, as the block itself does not enforce this.
//   Reset empties every slot and sets the memory size to 65536.
// ---------------------------------------------------------------------------
`default_nettype none
module best_fit_segment_allocator_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bfsa_req_if.sink   req,
    bfsa_rsp_if.source rsp,
    bfsa_cfg_if.sink   cfg
);
    localparam int N = bfsa_pkg::MAX_SEGMENTS;

    bfsa_pkg::state_t                 state_reg, state_next;
    logic [bfsa_pkg::MSZ_W-1:0]       msize_reg;
    logic [bfsa_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [bfsa_pkg::ID_W-1:0]        id_reg;
    logic [bfsa_pkg::SIZE_W-1:0]      size_reg;
    logic [bfsa_pkg::TIME_W-1:0]      life_reg;
    logic                             found_reg, found_next;
    logic [bfsa_pkg::LIM_W-1:0]       best_sz_reg, best_sz_next;
    logic [bfsa_pkg::LIM_W-1:0]       best_s_reg, best_s_next;
    logic [bfsa_pkg::STATUS_W-1:0]    pst_reg, pst_next;
    logic [bfsa_pkg::BASE_W-1:0]      pbase_reg, pbase_next;
    logic [bfsa_pkg::COUNT_W-1:0]     pcnt_reg, pcnt_next;
    logic                             ovld_reg;
    logic [bfsa_pkg::STATUS_W-1:0]    ost_reg;
    logic [bfsa_pkg::BASE_W-1:0]      obase_reg;
    logic [bfsa_pkg::COUNT_W-1:0]     ocnt_reg;

    bfsa_pkg::ctl_t                   ctl;
    bfsa_pkg::tok_t                   tok_head;
    bfsa_pkg::tok_t                   tok [N+1];
    bfsa_pkg::slot_t                  slots [N];
    logic [N-1:0]                     wr_sel, match_vec;
    logic                             accept, exists, has_free, push, load_out;
    logic [bfsa_pkg::SLOT_W-1:0]      free_idx, inj_idx;
    logic [bfsa_pkg::LIM_W-1:0]       limit, gap_sz;
    logic [bfsa_pkg::ADDR_BITS-1:0]   free_base;
    logic [bfsa_pkg::POP_W-1:0]       rel_cnt;
    logic [bfsa_pkg::END_W-1:0]       inj_end;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == bfsa_pkg::S_IDLE);
    assign cfg.ready = 1'b1;

    // usable memory limit, capped at the address space
    assign limit = (64'(msize_reg) >= (64'(1) << bfsa_pkg::ADDR_BITS))
                 ? bfsa_pkg::LIM_W'(64'(1) << bfsa_pkg::ADDR_BITS)
                 : bfsa_pkg::LIM_W'(msize_reg);

    // broadcast control
    always_comb
    begin
        ctl.tick    = accept && (req.operation == bfsa_pkg::OP_TICK);
        ctl.free    = accept && (req.operation == bfsa_pkg::OP_FREE);
        ctl.delta   = req.delta;
        ctl.id      = (state_reg == bfsa_pkg::S_IDLE) ? req.proc_id : id_reg;
        ctl.wr_base = bfsa_pkg::ADDR_BITS'(best_s_reg);
        ctl.wr_size = size_reg;
        ctl.wr_time = life_reg;
    end

    // slot summaries: id match, lowest free slot, freed base, expiry count
    always_comb
    begin
        has_free  = 1'b0;
        free_idx  = '0;
        free_base = '0;
        rel_cnt   = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            match_vec[i] = slots[i].id_match;
            if (!slots[i].valid)
            begin
                has_free = 1'b1;
                free_idx = bfsa_pkg::SLOT_W'(i);
            end
            if (slots[i].id_match)
                free_base = free_base | slots[i].base;
            rel_cnt = rel_cnt + bfsa_pkg::POP_W'(slots[i].expire);
        end
        exists = |match_vec;
    end

    // token injection at the head of the row
    assign inj_idx = bfsa_pkg::SLOT_W'(cnt_reg - 1'b1);
    assign inj_end = slots[inj_idx].seg_end;

    always_comb
    begin
        tok_head.e   = limit;
        tok_head.s   = '0;
        tok_head.vld = 1'b0;
        if (state_reg == bfsa_pkg::S_SCAN)
        begin
            if (cnt_reg == '0)
            begin
                tok_head.vld = (limit != '0);
            end
            else if (cnt_reg <= bfsa_pkg::CNT_W'(N))
            begin
                tok_head.s   = bfsa_pkg::LIM_W'(inj_end);
                tok_head.vld = slots[inj_idx].valid
                            && (inj_end < bfsa_pkg::END_W'(limit));
            end
        end
    end

    assign tok[0] = tok_head;

    // row of slot cells
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        assign wr_sel[g] = (state_reg == bfsa_pkg::S_FIN) && found_reg && has_free
                        && (free_idx == bfsa_pkg::SLOT_W'(g));
        bfsa_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .wr_sel  (wr_sel[g]),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .slot    (slots[g])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfsa_pkg::S_IDLE:
                if (accept)
                begin
                    if (req.operation == bfsa_pkg::OP_ALLOC && !exists
                        && req.req_size != '0)
                        state_next = bfsa_pkg::S_SCAN;
                    else
                        state_next = bfsa_pkg::S_PUSH;
                end
            bfsa_pkg::S_SCAN:
                if (cnt_reg == bfsa_pkg::CNT_W'(2 * N))
                    state_next = bfsa_pkg::S_FIN;
            bfsa_pkg::S_FIN:
                state_next = bfsa_pkg::S_PUSH;
            bfsa_pkg::S_PUSH:
                if (load_out)
                    state_next = bfsa_pkg::S_IDLE;
            default:
                state_next = bfsa_pkg::S_IDLE;
        endcase
    end

    // outputs of the controller: scan bookkeeping and pending response
    assign gap_sz   = tok[N].e - tok[N].s;
    assign push     = (state_reg == bfsa_pkg::S_PUSH);
    assign load_out = push && (!ovld_reg || rsp.ready);

    always_comb
    begin
        cnt_next     = cnt_reg;
        found_next   = found_reg;
        best_sz_next = best_sz_reg;
        best_s_next  = best_s_reg;
        pst_next     = pst_reg;
        pbase_next   = pbase_reg;
        pcnt_next    = pcnt_reg;
        unique case (state_reg)
            bfsa_pkg::S_IDLE:
            begin
                cnt_next   = '0;
                found_next = 1'b0;
                pst_next   = bfsa_pkg::STS_OK;
                pbase_next = '0;
                pcnt_next  = '0;
                case (req.operation)
                    bfsa_pkg::OP_ALLOC:
                        if (exists)
                            pst_next = bfsa_pkg::STS_EXISTS;
                        else if (req.req_size == '0)
                            pst_next = bfsa_pkg::STS_NOMEM;
                    bfsa_pkg::OP_FREE:
                        if (exists)
                            pbase_next = bfsa_pkg::BASE_W'(free_base);
                        else
                            pst_next = bfsa_pkg::STS_NOTFOUND;
                    bfsa_pkg::OP_TICK:
                        pcnt_next = bfsa_pkg::COUNT_W'(rel_cnt);
                    default:
                        pst_next = bfsa_pkg::STS_OK;
                endcase
            end
            bfsa_pkg::S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (tok[N].vld && bfsa_pkg::CMP_W'(gap_sz) >= bfsa_pkg::CMP_W'(size_reg)
                    && (!found_reg || gap_sz < best_sz_reg
                        || (gap_sz == best_sz_reg && tok[N].s < best_s_reg)))
                begin
                    found_next   = 1'b1;
                    best_sz_next = gap_sz;
                    best_s_next  = tok[N].s;
                end
            end
            bfsa_pkg::S_FIN:
            begin
                if (!found_reg)
                    pst_next = bfsa_pkg::STS_NOMEM;
                else if (!has_free)
                    pst_next = bfsa_pkg::STS_FULL;
                else
                    pbase_next = bfsa_pkg::BASE_W'(best_s_reg);
            end
            bfsa_pkg::S_PUSH:
                cnt_next = cnt_reg;
            default:
                cnt_next = cnt_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfsa_pkg::S_IDLE;
            msize_reg <= bfsa_pkg::MEM_SIZE_RST;
            ovld_reg  <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
            if (cfg.valid && cfg.ready)
                msize_reg <= cfg.data;
            if (load_out)
                ovld_reg <= 1'b1;
            else if (rsp.ready)
                ovld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_sz_reg <= best_sz_next;
        best_s_reg  <= best_s_next;
        pst_reg     <= pst_next;
        pbase_reg   <= pbase_next;
        pcnt_reg    <= pcnt_next;
        if (accept)
        begin
            id_reg   <= req.proc_id;
            size_reg <= req.req_size;
            life_reg <= req.lifetime;
        end
        if (load_out)
        begin
            ost_reg   <= pst_reg;
            obase_reg <= pbase_reg;
            ocnt_reg  <= pcnt_reg;
        end
    end

    assign rsp.valid          = ovld_reg;
    assign rsp.status         = ost_reg;
    assign rsp.base_addr      = obase_reg;
    assign rsp.released_count = ocnt_reg;

    // live ids are unique
    a_id_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one slot matches the id");

    // a chosen gap always starts inside the memory
    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfsa_pkg::S_FIN && found_reg) |-> best_s_reg < limit)
        else $error("best gap starts beyond the memory limit");

    // at most one slot written per allocation
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_sel))
        else $error("several slots written at once");

    // a scan always ends in the finishing step
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfsa_pkg::S_SCAN && cnt_reg == bfsa_pkg::CNT_W'(2 * N))
        |=> state_reg == bfsa_pkg::S_FIN)
        else $error("scan did not finish");

endmodule
`default_nettype wire

[verif/bfsa_tb_if.sv]
// ---------------------------------------------------------------------------
// bfsa_tb_if: note on the channel interfaces used by the testbench
// The request, response and configuration channels are the interfaces of
// rtl/bfsa_if.sv; this file only holds the helper types of the testbench.
// ---------------------------------------------------------------------------
package bfsa_tb_pkg;

    // one request as the testbench builds it
    typedef struct packed {
        bfsa_pkg::op_t                  op;
        logic [bfsa_pkg::ID_W-1:0]      id;
        logic [bfsa_pkg::SIZE_W-1:0]    size;
        logic [bfsa_pkg::TIME_W-1:0]    life;
        logic [bfsa_pkg::TIME_W-1:0]    delta;
    } bfsa_item_t;

    // one predicted response
    typedef struct packed {
        bfsa_pkg::status_t              status;
        logic [bfsa_pkg::BASE_W-1:0]    base;
        logic [bfsa_pkg::COUNT_W-1:0]   released;
    } bfsa_resp_t;
endpackage

[verif/best_fit_segment_allocator_top_tb.sv]
// ---------------------------------------------------------------------------
// best_fit_segment_allocator_top_tb: self-checking bench for the allocator
// Drives allocate, free, tick and unknown requests, predicts each response
// with a behavioural best-fit model and compares every field in order.
// ---------------------------------------------------------------------------
module best_fit_segment_allocator_top_tb;

    logic clk;
    logic rst_n;

    bfsa_req_if req_ch ();
    bfsa_rsp_if rsp_ch ();
    bfsa_cfg_if cfg_ch ();

    best_fit_segment_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // model state
    logic [bfsa_pkg::MSZ_W-1:0]  mem_size;
    logic                        seg_live [bfsa_pkg::MAX_SEGMENTS];
    logic [bfsa_pkg::ID_W-1:0]   seg_id   [bfsa_pkg::MAX_SEGMENTS];
    logic [16:0]                 seg_base [bfsa_pkg::MAX_SEGMENTS];
    logic [17:0]                 seg_len  [bfsa_pkg::MAX_SEGMENTS];
    logic [bfsa_pkg::TIME_W-1:0] seg_life [bfsa_pkg::MAX_SEGMENTS];

    bfsa_tb_pkg::bfsa_resp_t pending_rsp[$];
    int         error_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    logic       recv_hold;

    // clock and single reset
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // mismatch reporting
    task automatic report_mismatch(input string what);
        $display("mismatch: %s at %0t", what, $realtime);
        error_count++;
    endtask

    // best-fit search over the gaps below the current limit
    function automatic logic find_best_gap(input logic [17:0] want,
                                           output logic [16:0] start);
        logic [17:0] limit;
        logic [17:0] s;
        logic [17:0] e;
        logic [17:0] best_sz;
        logic [17:0] best_st;
        logic        found;
        limit = (mem_size > 17'd65536) ? 18'd65536 : 18'(mem_size);
        found = 1'b0;
        best_sz = '0;
        best_st = '0;
        for (int i = -1; i < bfsa_pkg::MAX_SEGMENTS; i++)
        begin
            if (i < 0)
                s = '0;
            else if (!seg_live[i])
                continue;
            else
                s = 18'(seg_base[i]) + seg_len[i];
            if (s >= limit)
                continue;
            e = limit;
            for (int j = 0; j < bfsa_pkg::MAX_SEGMENTS; j++)
                if (seg_live[j] && 18'(seg_base[j]) >= s && 18'(seg_base[j]) < e)
                    e = 18'(seg_base[j]);
            if (e - s < want)
                continue;
            if (!found || e - s < best_sz || (e - s == best_sz && s < best_st))
            begin
                found = 1'b1;
                best_sz = e - s;
                best_st = s;
            end
        end
        start = best_st[16:0];
        return found;
    endfunction

    // apply one request to the model and return the response
    function automatic bfsa_tb_pkg::bfsa_resp_t apply_request(
        input bfsa_tb_pkg::bfsa_item_t it);
        bfsa_tb_pkg::bfsa_resp_t r;
        int free_slot;
        int hit;
        logic [16:0] where;
        r.status = bfsa_pkg::STS_OK;
        r.base = '0;
        r.released = '0;
        free_slot = -1;
        hit = -1;
        for (int i = bfsa_pkg::MAX_SEGMENTS - 1; i >= 0; i--)
        begin
            if (!seg_live[i])
                free_slot = i;
            if (seg_live[i] && seg_id[i] == it.id)
                hit = i;
        end
        case (it.op)
            bfsa_pkg::OP_ALLOC:
            begin
                if (hit >= 0)
                    r.status = bfsa_pkg::STS_EXISTS;
                else if (it.size == 0 || !find_best_gap(18'(it.size), where))
                    r.status = bfsa_pkg::STS_NOMEM;
                else if (free_slot < 0)
                    r.status = bfsa_pkg::STS_FULL;
                else
                begin
                    seg_live[free_slot] = 1'b1;
                    seg_id[free_slot] = it.id;
                    seg_base[free_slot] = where;
                    seg_len[free_slot] = 18'(it.size);
                    seg_life[free_slot] = it.life;
                    r.base = where[15:0];
                end
            end
            bfsa_pkg::OP_FREE:
            begin
                if (hit < 0)
                    r.status = bfsa_pkg::STS_NOTFOUND;
                else
                begin
                    r.base = seg_base[hit][15:0];
                    seg_live[hit] = 1'b0;
                end
            end
            bfsa_pkg::OP_TICK:
            begin
                for (int i = 0; i < bfsa_pkg::MAX_SEGMENTS; i++)
                begin
                    if (!seg_live[i])
                        continue;
                    if (seg_life[i] <= it.delta)
                    begin
                        seg_live[i] = 1'b0;
                        r.released++;
                    end
                    else
                        seg_life[i] -= it.delta;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // send one request, predicting at acceptance; valid stays up until the
    // sender idles or waits for the block to drain
    task automatic send_request(input bfsa_tb_pkg::bfsa_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= it.op;
        req_ch.proc_id   <= it.id;
        req_ch.req_size  <= it.size;
        req_ch.lifetime  <= it.life;
        req_ch.delta     <= it.delta;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_rsp.push_back(apply_request(it));
    endtask

    // receiver readiness
    always @(posedge clk)
        rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    // response checker
    always @(posedge clk)
    begin
        bfsa_tb_pkg::bfsa_resp_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("response with none expected");
            else
            begin
                exp_r = pending_rsp.pop_front();
                if (rsp_ch.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp_ch.status, exp_r.status));
                if (rsp_ch.base_addr !== exp_r.base)
                    report_mismatch($sformatf("base %0d, want %0d",
                                              rsp_ch.base_addr, exp_r.base));
                if (rsp_ch.released_count !== exp_r.released)
                    report_mismatch($sformatf("released %0d, want %0d",
                                              rsp_ch.released_count, exp_r.released));
            end
        end
    end

    // stop offering requests and wait for every response
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // memory size write while idle
    task automatic write_mem_size(input logic [bfsa_pkg::MSZ_W-1:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        mem_size = value;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic bfsa_tb_pkg::bfsa_item_t make_item(input bfsa_pkg::op_t op,
                                                          input int id,
                                                          input int size,
                                                          input logic [31:0] life,
                                                          input logic [31:0] delta);
        bfsa_tb_pkg::bfsa_item_t it;
        it.op = op;
        it.id = bfsa_pkg::ID_W'(id);
        it.size = bfsa_pkg::SIZE_W'(size);
        it.life = life;
        it.delta = delta;
        return it;
    endfunction

    // random request: mostly allocate/free over a small id pool
    function automatic bfsa_tb_pkg::bfsa_item_t random_item(input int max_size);
        bfsa_tb_pkg::bfsa_item_t it;
        int pick;
        pick = $urandom_range(99);
        it.id = ($urandom_range(3) == 0) ? bfsa_pkg::ID_W'($urandom)
                                         : bfsa_pkg::ID_W'($urandom_range(23));
        it.size = ($urandom_range(15) == 0) ? bfsa_pkg::SIZE_W'($urandom)
                                            : bfsa_pkg::SIZE_W'($urandom_range(max_size));
        it.life = ($urandom_range(3) == 0) ? $urandom : $urandom_range(60);
        it.delta = ($urandom_range(7) == 0) ? $urandom : $urandom_range(12);
        if (pick < 50)
            it.op = bfsa_pkg::OP_ALLOC;
        else if (pick < 80)
            it.op = bfsa_pkg::OP_FREE;
        else if (pick < 96)
            it.op = bfsa_pkg::OP_TICK;
        else
            it.op = bfsa_pkg::OP_NONE;
        return it;
    endfunction

    task automatic test_directed();
        send_request(make_item(bfsa_pkg::OP_ALLOC, 16'hFFFF, 65536, 32'hFFFF_FFFF, 0));
        send_request(make_item(bfsa_pkg::OP_ALLOC, 1, 1, 5, 0));
        send_request(make_item(bfsa_pkg::OP_ALLOC, 16'hFFFF, 1, 5, 0));
        send_request(make_item(bfsa_pkg::OP_FREE, 16'hFFFF, 0, 0, 0));
        send_request(make_item(bfsa_pkg::OP_ALLOC, 0, 0, 0, 0));
        send_request(make_item(bfsa_pkg::OP_ALLOC, 2, 100, 0, 0));
        send_request(make_item(bfsa_pkg::OP_ALLOC, 3, 1, 3, 0));
        send_request(make_item(bfsa_pkg::OP_TICK, 0, 0, 0, 0));
        send_request(make_item(bfsa_pkg::OP_FREE, 2, 0, 0, 0));
        send_request(make_item(bfsa_pkg::OP_FREE, 7, 0, 0, 0));
        send_request(make_item(bfsa_pkg::OP_NONE, 16'hFFFF, 131071, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF));
        for (int i = 0; i < 17; i++)
            send_request(make_item(bfsa_pkg::OP_ALLOC, 100 + i, 1, 100, 0));
        send_request(make_item(bfsa_pkg::OP_TICK, 0, 0, 0, 32'hFFFF_FFFF));
    endtask

    task automatic test_size_extremes();
        write_mem_size('0);
        send_request(make_item(bfsa_pkg::OP_ALLOC, 5, 1, 1, 0));
        write_mem_size(17'h1FFFF);
        send_request(make_item(bfsa_pkg::OP_ALLOC, 5, 65536, 1, 0));
        send_request(make_item(bfsa_pkg::OP_TICK, 0, 0, 0, 1));
        write_mem_size(1);
        send_request(make_item(bfsa_pkg::OP_ALLOC, 6, 1, 1, 0));
        send_request(make_item(bfsa_pkg::OP_ALLOC, 7, 1, 1, 0));
        send_request(make_item(bfsa_pkg::OP_TICK, 0, 0, 0, 2));
    endtask

    task automatic test_random(input int count, input logic [bfsa_pkg::MSZ_W-1:0] msize,
                               input int max_size);
        write_mem_size(msize);
        for (int n = 0; n < count; n++)
            send_request(random_item(max_size));
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(posedge clk);
                recv_hold = 1'b0;
            end
            for (int n = 0; n < 20; n++)
                send_request(random_item(64));
        join
        wait_drained();
    endtask

    initial
    begin
        error_count = 0;
        recv_hold = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 50;
        mem_size = bfsa_pkg::MEM_SIZE_RST;
        for (int i = 0; i < bfsa_pkg::MAX_SEGMENTS; i++)
            seg_live[i] = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = bfsa_pkg::OP_NONE;
        req_ch.proc_id = '0;
        req_ch.req_size = '0;
        req_ch.lifetime = '0;
        req_ch.delta = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_size_extremes();
        test_random(450, 17'd256, 40);
        send_idle_pct = 50;
        recv_idle_pct = 10;
        test_random(450, 17'd65536, 9000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(400, 17'd100, 20);
        wait_drained();
        if (error_count == 0)
            $display("[best_fit_segment_allocator_top] OK");
        else
            $display("[best_fit_segment_allocator_top] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("[best_fit_segment_allocator_top] ERROR");
        $finish;
    end
endmodule
